// ----- hdl/gpf_pkg.sv -----
// Shared types, codes and constants of the grid path fitness checker.
package gpf_pkg;

  // Input item operation codes.
  typedef enum logic [1:0] {
    OP_CELL = 2'd0,
    OP_MOVE = 2'd1,
    OP_END  = 2'd2
  } opcode_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_GRID_SIZE = 3'd0,
    REG_START_X   = 3'd1,
    REG_START_Y   = 3'd2,
    REG_GOAL_X    = 3'd3,
    REG_GOAL_Y    = 3'd4
  } reg_index_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [6:0] grid_size;
    logic [5:0] start_x;
    logic [5:0] start_y;
    logic [5:0] goal_x;
    logic [5:0] goal_y;
  } cfg_t;

  // Classified motion record passed from the front end to the back end.
  typedef struct packed {
    logic open;
    logic start_goal;
    logic moved;
    logic add_cost;
    logic in_grid;
    logic at_goal;
    logic blocked;
    logic left;
    logic close;
  } step_flags_t;

  localparam int FLAG_W = $bits(step_flags_t);

  // Fitness codes: left the grid, and the saturation ceiling.
  localparam logic [30:0] FIT_LEFT = 31'h7FFF_FFFF;
  localparam logic [30:0] FIT_SAT  = 31'h7FFF_FFFE;

  // Record queue between front and back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPW = 2;
  localparam int QCW = 3;

endpackage

// ----- hdl/gpf_if.sv -----
// Channel interfaces of the grid path fitness checker.
interface gpf_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [5:0]        cell_row;
  logic [5:0]        cell_col;
  logic              cell_blocked;
  logic signed [1:0] step_dx;
  logic signed [1:0] step_dy;
  logic              last_step;

  modport source (output valid, opcode, cell_row, cell_col, cell_blocked, step_dx, step_dy,
                  last_step, input ready);
  modport sink (input valid, opcode, cell_row, cell_col, cell_blocked, step_dx, step_dy,
                last_step, output ready);
endinterface

interface gpf_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] fitness;
  logic        path_valid;
  logic        left_grid;

  modport source (output valid, fitness, path_valid, left_grid, input ready);
  modport sink (input valid, fitness, path_valid, left_grid, output ready);
endinterface

interface gpf_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] reg_index;
  logic [6:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ----- hdl/gpf_front.sv -----
// Front end: accepts items, tracks the path position and reads the obstacle map.
module gpf_front import gpf_pkg::*; #(
  parameter int MAX_GRID = 64,
  parameter int ADD_W = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  gpf_in_if.sink              in_ch,
  input  cfg_t                cfg,
  input  logic [QCW-1:0]      q_count,
  output logic                rec_valid,
  output step_flags_t         rec_flags,
  output logic [ADD_W-1:0]    rec_add
);

  localparam int SPAN = ((MAX_GRID > 64) ? MAX_GRID : 64) + 1;
  localparam int PW = $clog2(SPAN + 1) + 1;
  localparam int NW = $clog2(MAX_GRID + 1);
  localparam int IW = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;

  // Obstacle map, one row per word.
  logic [MAX_GRID-1:0] obs_mem [MAX_GRID];
  logic [MAX_GRID-1:0] rd_row_r;

  logic clr_active_r, clr_active_nxt;
  logic [IW-1:0] clr_row_r, clr_row_nxt;

  logic path_open_r, path_open_nxt;
  logic fit_done_r, fit_done_nxt;
  logic fit_out_r, fit_out_nxt;
  logic signed [PW-1:0] row_r, row_nxt;
  logic signed [PW-1:0] col_r, col_nxt;

  logic f2_valid_r, f2_valid_nxt;
  step_flags_t f2_flags_r, f2_flags_nxt;
  logic [PW-1:0] f2_d_r, f2_d_nxt;
  logic [NW-1:0] f2_n_r;
  logic [IW-1:0] f2_col_r, f2_col_nxt;

  logic accept;
  logic wr_en;
  logic [IW-1:0] wr_row, wr_col, rd_idx;
  logic [NW-1:0] n_eff;
  logic blocked;

  logic open_now, start_goal, base_done, base_out, in_grid, at_goal;
  logic signed [PW-1:0] base_row, base_col, step_row, step_col;
  logic signed [PW:0] dr, dc;
  logic [PW:0] ar, ac;

  // Accept while the map is ready and the queue has room for one more record.
  assign in_ch.ready = !clr_active_r && ((32'(q_count) + 32'(f2_valid_r)) < QUEUE_DEPTH);
  assign accept = in_ch.valid && in_ch.ready;

  // Grid side in use, limited to the map size.
  assign n_eff = (32'(cfg.grid_size) > MAX_GRID) ? NW'(MAX_GRID) : NW'(cfg.grid_size);

  // Cell write decode; rows or columns beyond the map are dropped.
  assign wr_row = IW'(in_ch.cell_row);
  assign wr_col = IW'(in_ch.cell_col);
  assign wr_en = accept && (in_ch.opcode == OP_CELL) &&
                 (32'(in_ch.cell_row) < MAX_GRID) && (32'(in_ch.cell_col) < MAX_GRID);

  // Position update, bounds, goal test and Manhattan distance of the new cell.
  always_comb begin
    open_now   = !path_open_r;
    start_goal = (cfg.start_x == cfg.goal_x) && (cfg.start_y == cfg.goal_y);
    base_row   = open_now ? $signed(PW'(cfg.start_x)) : row_r;
    base_col   = open_now ? $signed(PW'(cfg.start_y)) : col_r;
    base_done  = open_now ? 1'b0 : fit_done_r;
    base_out   = open_now ? 1'b0 : fit_out_r;
    step_row   = base_row + PW'(in_ch.step_dx);
    step_col   = base_col + PW'(in_ch.step_dy);
    in_grid    = !step_row[PW-1] && !step_col[PW-1] &&
                 ($unsigned(step_row) < PW'(n_eff)) && ($unsigned(step_col) < PW'(n_eff));
    at_goal    = ($unsigned(step_row) == PW'(cfg.goal_x)) &&
                 ($unsigned(step_col) == PW'(cfg.goal_y));
    dr = $signed((PW+1)'(cfg.goal_x)) - (PW+1)'(step_row);
    dc = $signed((PW+1)'(cfg.goal_y)) - (PW+1)'(step_col);
    ar = dr[PW] ? $unsigned(-dr) : $unsigned(dr);
    ac = dc[PW] ? $unsigned(-dc) : $unsigned(dc);
    rd_idx = step_row[IW-1:0];
  end

  // Path state and record classification.
  always_comb begin
    path_open_nxt = path_open_r;
    fit_done_nxt  = fit_done_r;
    fit_out_nxt   = fit_out_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    f2_valid_nxt  = 1'b0;
    f2_flags_nxt  = '0;
    f2_d_nxt      = PW'(ar[PW-2:0]) + PW'(ac[PW-2:0]);
    f2_col_nxt    = step_col[IW-1:0];
    if (accept) begin
      case (in_ch.opcode)
        OP_MOVE: begin
          row_nxt      = base_row;
          col_nxt      = base_col;
          fit_done_nxt = base_done;
          fit_out_nxt  = base_out;
          if (!base_done) begin
            row_nxt = step_row;
            col_nxt = step_col;
            if (!in_grid) begin
              fit_out_nxt  = 1'b1;
              fit_done_nxt = 1'b1;
            end else if (at_goal) begin
              fit_done_nxt = 1'b1;
            end
          end
          path_open_nxt           = !in_ch.last_step;
          f2_valid_nxt            = 1'b1;
          f2_flags_nxt.open       = open_now;
          f2_flags_nxt.start_goal = start_goal;
          f2_flags_nxt.moved      = !base_done;
          f2_flags_nxt.add_cost   = !base_done && in_grid && !at_goal;
          f2_flags_nxt.in_grid    = in_grid;
          f2_flags_nxt.at_goal    = at_goal;
          f2_flags_nxt.left       = fit_out_nxt;
          f2_flags_nxt.close      = in_ch.last_step;
        end
        OP_END: begin
          row_nxt                 = base_row;
          col_nxt                 = base_col;
          fit_done_nxt            = base_done;
          fit_out_nxt             = base_out;
          path_open_nxt           = 1'b0;
          f2_valid_nxt            = 1'b1;
          f2_flags_nxt.open       = open_now;
          f2_flags_nxt.start_goal = start_goal;
          f2_flags_nxt.left       = base_out;
          f2_flags_nxt.close      = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Clearing pass over the map rows after reset.
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_row_nxt    = clr_row_r;
    if (clr_active_r) begin
      clr_row_nxt = clr_row_r + 1'b1;
      if (clr_row_r == IW'(MAX_GRID - 1)) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_row_r    <= '0;
      path_open_r  <= 1'b0;
      fit_done_r   <= 1'b0;
      fit_out_r    <= 1'b0;
      row_r        <= '0;
      col_r        <= '0;
      f2_valid_r   <= 1'b0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_row_r    <= clr_row_nxt;
      path_open_r  <= path_open_nxt;
      fit_done_r   <= fit_done_nxt;
      fit_out_r    <= fit_out_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      f2_valid_r   <= f2_valid_nxt;
    end
  end

  // Second stage payload.
  always_ff @(posedge clk) begin
    f2_flags_r <= f2_flags_nxt;
    f2_d_r     <= f2_d_nxt;
    f2_n_r     <= n_eff;
    f2_col_r   <= f2_col_nxt;
  end

  // Obstacle map: clear, cell write and registered row read.
  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      obs_mem[clr_row_r] <= '0;
    end else if (wr_en) begin
      obs_mem[wr_row][wr_col] <= in_ch.cell_blocked;
    end
    rd_row_r <= obs_mem[rd_idx];
  end

  // An obstacle counts only inside the grid; it scales the distance by the grid side.
  assign blocked = f2_flags_r.in_grid && rd_row_r[f2_col_r];

  always_comb begin
    rec_flags         = f2_flags_r;
    rec_flags.blocked = blocked;
    rec_add = blocked ? (ADD_W'(f2_d_r) * ADD_W'(f2_n_r)) : ADD_W'(f2_d_r);
  end

  assign rec_valid = f2_valid_r;

endmodule

// ----- hdl/gpf_queue.sv -----
// Short record queue that decouples the front end from the back end.
module gpf_queue import gpf_pkg::*; #(
  parameter int WIDTH = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data,
  output logic [QCW-1:0]   count
);

  logic [WIDTH-1:0] slot_r [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;

  assign pop_valid = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign count     = count_r;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // The front end must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> count_r < QCW'(QUEUE_DEPTH))
    else $error("record queue overflow");

endmodule

// ----- hdl/gpf_back.sv -----
// Back end: cost accumulation, validity walk and the result register.
module gpf_back import gpf_pkg::*; #(
  parameter int ADD_W = 15
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  step_flags_t      q_flags,
  input  logic [ADD_W-1:0] q_add,
  output logic             pop,
  gpf_out_if.source        out_ch
);

  logic [30:0] cost_r, cost_nxt;
  logic chk_done_r, chk_done_nxt;
  logic chk_ok_r, chk_ok_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [30:0] out_fitness_r, out_fitness_nxt;
  logic out_path_valid_r, out_path_valid_nxt;
  logic out_left_r, out_left_nxt;

  logic [30:0] cost0;
  logic cd0, ok0;
  logic [31:0] sum;

  // A closing record needs a free result register; others retire at once.
  assign pop = q_valid && (!q_flags.close || !out_valid_r || out_ch.ready);

  always_comb begin
    cost0 = q_flags.open ? '0 : cost_r;
    cd0   = q_flags.open ? q_flags.start_goal : chk_done_r;
    ok0   = q_flags.open ? q_flags.start_goal : chk_ok_r;
    sum   = 32'(cost0) + 32'(q_add);

    cost_nxt           = cost_r;
    chk_done_nxt       = chk_done_r;
    chk_ok_nxt         = chk_ok_r;
    out_valid_nxt      = out_valid_r && !out_ch.ready;
    out_fitness_nxt    = out_fitness_r;
    out_path_valid_nxt = out_path_valid_r;
    out_left_nxt       = out_left_r;

    if (pop) begin
      // Saturating cost sum.
      cost_nxt     = cost0;
      chk_done_nxt = cd0;
      chk_ok_nxt   = ok0;
      if (q_flags.add_cost) begin
        cost_nxt = (sum > 32'(FIT_SAT)) ? FIT_SAT : sum[30:0];
      end
      // Validity walk tests the goal first, then bounds and obstacles.
      if (q_flags.moved && !cd0) begin
        if (q_flags.at_goal) begin
          chk_done_nxt = 1'b1;
          chk_ok_nxt   = 1'b1;
        end else if (!q_flags.in_grid || q_flags.blocked) begin
          chk_done_nxt = 1'b1;
          chk_ok_nxt   = 1'b0;
        end
      end
      // Load the result when the path ends.
      if (q_flags.close) begin
        out_valid_nxt      = 1'b1;
        out_fitness_nxt    = q_flags.left ? FIT_LEFT : cost_nxt;
        out_path_valid_nxt = chk_done_nxt && chk_ok_nxt;
        out_left_nxt       = q_flags.left;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r      <= '0;
      chk_done_r  <= 1'b0;
      chk_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cost_r      <= cost_nxt;
      chk_done_r  <= chk_done_nxt;
      chk_ok_r    <= chk_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_fitness_r    <= out_fitness_nxt;
    out_path_valid_r <= out_path_valid_nxt;
    out_left_r       <= out_left_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.fitness    = out_fitness_r;
  assign out_ch.path_valid = out_path_valid_r;
  assign out_ch.left_grid  = out_left_r;

  // A passing verdict is always a finished one.
  a_ok_done: assert property (@(posedge clk) disable iff (!rst_n)
    chk_ok_r |-> chk_done_r)
    else $error("validity set without a decision");

  // The running sum never reaches the left-grid code.
  a_cost_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cost_r <= FIT_SAT)
    else $error("cost sum above saturation");

  // A path that left the grid reports the left-grid fitness code.
  a_left_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_left_r |-> out_fitness_r == FIT_LEFT)
    else $error("left-grid result with wrong fitness");

endmodule

// ----- hdl/grid_path_fitness_checker.sv -----
// Top level of the grid path fitness checker: config registers, front end, queue, back end.
// out_ch.valid follows the closing item via the front stage, queue and result registers.
// One item per cycle while in_ch.ready; the front end registers its obstacle map row read.
// Reset: rst_n is synchronous; afterwards a clearing pass writes MAX_GRID map rows, one per
// cycle, while in_ch.ready stays low. Configuration writes are taken throughout.
module grid_path_fitness_checker import gpf_pkg::*; #(
  parameter int MAX_GRID = 64
) (
  input logic        clk,
  input logic        rst_n,
  gpf_in_if.sink     in_ch,
  gpf_out_if.source  out_ch,
  gpf_cfg_if.sink    cfg_ch
);

  localparam int SPAN = ((MAX_GRID > 64) ? MAX_GRID : 64) + 1;
  localparam int PW = $clog2(SPAN + 1) + 1;
  localparam int NW = $clog2(MAX_GRID + 1);
  localparam int ADD_W = PW + NW;
  localparam int REC_W = FLAG_W + ADD_W;

  cfg_t cfg_r, cfg_nxt;

  logic rec_valid;
  step_flags_t rec_flags;
  logic [ADD_W-1:0] rec_add;
  logic q_pop, q_valid;
  logic [REC_W-1:0] q_data;
  logic [QCW-1:0] q_count;
  step_flags_t q_flags;
  logic [ADD_W-1:0] q_add;

  // Configuration registers; every transfer is taken at once.
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        REG_GRID_SIZE: cfg_nxt.grid_size = cfg_ch.wdata;
        REG_START_X:   cfg_nxt.start_x   = cfg_ch.wdata[5:0];
        REG_START_Y:   cfg_nxt.start_y   = cfg_ch.wdata[5:0];
        REG_GOAL_X:    cfg_nxt.goal_x    = cfg_ch.wdata[5:0];
        REG_GOAL_Y:    cfg_nxt.goal_y    = cfg_ch.wdata[5:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_size <= 7'd64;
      cfg_r.start_x   <= '0;
      cfg_r.start_y   <= '0;
      cfg_r.goal_x    <= '0;
      cfg_r.goal_y    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gpf_front #(
    .MAX_GRID (MAX_GRID),
    .ADD_W    (ADD_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .q_count   (q_count),
    .rec_valid (rec_valid),
    .rec_flags (rec_flags),
    .rec_add   (rec_add)
  );

  gpf_queue #(
    .WIDTH (REC_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_valid),
    .push_data ({rec_flags, rec_add}),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data),
    .count     (q_count)
  );

  // Split the queued record back into flags and cost increment.
  assign q_flags = step_flags_t'(q_data[REC_W-1:ADD_W]);
  assign q_add   = q_data[ADD_W-1:0];

  gpf_back #(
    .ADD_W (ADD_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_flags (q_flags),
    .q_add   (q_add),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

endmodule
